>>> sv/jtpm_pkg.sv
// Shared widths, queue entry type and reset constants for the joint-space
// trajectory path metrics block. No dependencies.
package jtpm_pkg;

  localparam int unsigned InJoints = 6;
  localparam int unsigned TimeW    = 48;
  localparam int unsigned PosW     = 20;
  localparam int unsigned LenW     = 40;
  localparam int unsigned DurW     = 47;
  localparam int unsigned JntW     = 3;
  localparam int unsigned SqW      = 2 * PosW;
  localparam int unsigned SumW     = SqW + 3;
  localparam int unsigned RootW    = (SumW + 1) / 2;
  localparam int unsigned RadW     = 2 * RootW;
  localparam int unsigned RemW     = RootW + 3;
  localparam int unsigned IterW    = $clog2(RootW);

  localparam logic [JntW-1:0] ActiveJointsRst = JntW'(6);

  typedef logic [JntW-1:0] jcnt_t;

  typedef struct packed {
    logic signed [TimeW-1:0]        time_ns;
    logic [InJoints-1:0][PosW-1:0]  joint_pos;
    logic                           last_point;
    logic                           time_neg;
    jcnt_t                          n_joints;
  } jtpm_entry_t;

endpackage

>>> sv/jtpm_point_if.sv
// Trajectory point channel: valid/ready handshake and point payload.
// Depends on jtpm_pkg.
interface jtpm_point_if import jtpm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TimeW-1:0] time_ns;
  logic signed [PosW-1:0]  joint_pos_0;
  logic signed [PosW-1:0]  joint_pos_1;
  logic signed [PosW-1:0]  joint_pos_2;
  logic signed [PosW-1:0]  joint_pos_3;
  logic signed [PosW-1:0]  joint_pos_4;
  logic signed [PosW-1:0]  joint_pos_5;
  logic                    last_point;

  modport source (
    output valid, time_ns, joint_pos_0, joint_pos_1, joint_pos_2,
           joint_pos_3, joint_pos_4, joint_pos_5, last_point,
    input  ready
  );
  modport sink (
    input  valid, time_ns, joint_pos_0, joint_pos_1, joint_pos_2,
           joint_pos_3, joint_pos_4, joint_pos_5, last_point,
    output ready
  );
endinterface

>>> sv/jtpm_result_if.sv
// Path metrics result channel: valid/ready handshake and result payload.
// Depends on jtpm_pkg.
interface jtpm_result_if import jtpm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            status;
  logic [LenW-1:0] path_len;
  logic [DurW-1:0] duration_ns;
  logic [PosW-1:0] max_joint_travel;

  modport source (
    output valid, status, path_len, duration_ns, max_joint_travel,
    input  ready
  );
  modport sink (
    input  valid, status, path_len, duration_ns, max_joint_travel,
    output ready
  );
endinterface

>>> sv/joint_trajectory_path_metrics.sv
// Joint-space trajectory path metrics, top level.
// In the back end a valid later point takes one squared delta per cycle over
// the n joints in use, then a 22-step one-bit-per-cycle square root; first,
// failing and post-error points skip both, and a last point adds an emit step.
// The back end takes a new point only when idle; a two-entry queue decouples intake.
// Reset clears all trajectory state and sets active_joints to six.
module joint_trajectory_path_metrics import jtpm_pkg::*; #(
  parameter int unsigned MAX_JOINTS = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  jtpm_point_if.sink      pt_i,
  jtpm_result_if.source   res_o,
  input  logic            cfg_we_i,
  input  logic [JntW-1:0] cfg_wdata_i
);

  localparam int unsigned NumJ = (MAX_JOINTS < InJoints) ? MAX_JOINTS : InJoints;

  logic        push, full, pop, q_valid;
  jtpm_entry_t push_entry, q_entry;

  jtpm_front #(
    .NUM_JOINTS (NumJ)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pt_i        (pt_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  jtpm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  jtpm_back #(
    .NUM_JOINTS (NumJ)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .pop_o     (pop),
    .res_o     (res_o)
  );

endmodule

>>> sv/jtpm_front.sv
// Front end: joint count register, item intake and classification into
// queue entries. Depends on jtpm_pkg and jtpm_point_if.
module jtpm_front import jtpm_pkg::*; #(
  parameter int unsigned NUM_JOINTS = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  jtpm_point_if.sink       pt_i,
  input  logic             cfg_we_i,
  input  logic [JntW-1:0]  cfg_wdata_i,
  input  logic             q_full_i,
  output logic             push_o,
  output jtpm_entry_t      entry_o
);

  logic [JntW-1:0] active_q;
  jcnt_t           n_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActiveJointsRst;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (active_q == '0) begin
      n_use = JntW'(1);
    end else if (active_q > JntW'(NUM_JOINTS)) begin
      n_use = JntW'(NUM_JOINTS);
    end else begin
      n_use = active_q;
    end
  end

  assign pt_i.ready = !q_full_i;
  assign push_o     = pt_i.valid && !q_full_i;

  always_comb begin
    entry_o.time_ns      = pt_i.time_ns;
    entry_o.joint_pos[0] = pt_i.joint_pos_0;
    entry_o.joint_pos[1] = pt_i.joint_pos_1;
    entry_o.joint_pos[2] = pt_i.joint_pos_2;
    entry_o.joint_pos[3] = pt_i.joint_pos_3;
    entry_o.joint_pos[4] = pt_i.joint_pos_4;
    entry_o.joint_pos[5] = pt_i.joint_pos_5;
    entry_o.last_point   = pt_i.last_point;
    entry_o.time_neg     = pt_i.time_ns[TimeW-1];
    entry_o.n_joints     = n_use;
  end

endmodule

>>> sv/jtpm_queue.sv
// Two-entry item queue between front and back end.
// Depends on jtpm_pkg.
module jtpm_queue import jtpm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  jtpm_entry_t entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output jtpm_entry_t entry_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  jtpm_entry_t     mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PtrW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

>>> sv/jtpm_back.sv
// Back end: time checks, squared-delta sum, bit-serial square root,
// saturating path length, travel and result register.
// Depends on jtpm_pkg and jtpm_result_if.
module jtpm_back import jtpm_pkg::*; #(
  parameter int unsigned NUM_JOINTS = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  jtpm_entry_t   q_entry_i,
  output logic          pop_o,
  jtpm_result_if.source res_o
);

  localparam int unsigned IdxW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSq   = 3'd1;
  localparam logic [2:0] StSqrt = 3'd2;
  localparam logic [2:0] StAcc  = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0]              st_q, st_d;
  logic [PosW-1:0]         prev_q [NUM_JOINTS];
  logic [PosW-1:0]         start_q [NUM_JOINTS];
  logic [PosW-1:0]         prev_d [NUM_JOINTS];
  logic [PosW-1:0]         start_d [NUM_JOINTS];
  logic signed [TimeW-1:0] ptime_q, ptime_d;
  logic [LenW-1:0]         acc_q, acc_d;
  logic                    await_q, await_d;
  logic                    err_q, err_d;

  jtpm_entry_t             cur_q, cur_d;
  jcnt_t                   k_q, k_d;
  logic [SqW-1:0]          prod_q, prod_d;
  logic [SumW-1:0]         sum_q, sum_d;
  logic [RadW-1:0]         rad_q, rad_d;
  logic [RemW-1:0]         rem_q, rem_d;
  logic [RootW-1:0]        root_q, root_d;
  logic [IterW-1:0]        it_q, it_d;

  logic                    rv_q, rv_d;
  logic                    rs_q, rs_d;
  logic [LenW-1:0]         rlen_q, rlen_d;
  logic [DurW-1:0]         rdur_q, rdur_d;
  logic [PosW-1:0]         rtrv_q, rtrv_d;

  logic signed [PosW:0]    dlt;
  logic [PosW-1:0]         dmag;
  logic [RemW-1:0]         rem_sh, trial;
  logic [LenW:0]           acc_sum;
  logic [PosW-1:0]         trav;
  logic signed [PosW:0]    tdl [NUM_JOINTS];
  logic [PosW-1:0]         tmag [NUM_JOINTS];
  logic                    out_free;

  assign out_free       = !rv_q || res_o.ready;
  assign pop_o          = (st_q == StIdle) && q_valid_i;
  assign res_o.valid            = rv_q;
  assign res_o.status           = rs_q;
  assign res_o.path_len         = rlen_q;
  assign res_o.duration_ns      = rdur_q;
  assign res_o.max_joint_travel = rtrv_q;

  // delta magnitude for the joint under k_q
  always_comb begin
    dlt  = $signed({cur_q.joint_pos[k_q][PosW-1], cur_q.joint_pos[k_q]})
         - $signed({prev_q[k_q[IdxW-1:0]][PosW-1], prev_q[k_q[IdxW-1:0]]});
    dmag = dlt[PosW] ? PosW'(-dlt) : dlt[PosW-1:0];
  end

  always_comb begin
    rem_sh  = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
    trial   = RemW'({root_q, 2'b01});
    acc_sum = {1'b0, acc_q} + (LenW + 1)'(root_q);
  end

  // largest |goal - start| over the joints in use
  always_comb begin
    trav = '0;
    for (int j = 0; j < NUM_JOINTS; j++) begin
      tdl[j]  = $signed({cur_q.joint_pos[j][PosW-1], cur_q.joint_pos[j]})
              - $signed({start_q[j][PosW-1], start_q[j]});
      tmag[j] = tdl[j][PosW] ? PosW'(-tdl[j]) : tdl[j][PosW-1:0];
      if (JntW'(j) < cur_q.n_joints && tmag[j] > trav) begin
        trav = tmag[j];
      end
    end
  end

  always_comb begin
    st_d    = st_q;
    prev_d  = prev_q;
    start_d = start_q;
    ptime_d = ptime_q;
    acc_d   = acc_q;
    await_d = await_q;
    err_d   = err_q;
    cur_d   = cur_q;
    k_d     = k_q;
    prod_d  = prod_q;
    sum_d   = sum_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    it_d    = it_q;
    rv_d    = rv_q && !res_o.ready;
    rs_d    = rs_q;
    rlen_d  = rlen_q;
    rdur_d  = rdur_q;
    rtrv_d  = rtrv_q;

    unique case (st_q)
      StIdle: begin
        if (q_valid_i) begin
          cur_d = q_entry_i;
          if (err_q) begin
            st_d = q_entry_i.last_point ? StEmit : StIdle;
          end else if (q_entry_i.time_neg ||
                       (!await_q && (q_entry_i.time_ns < ptime_q))) begin
            err_d = 1'b1;
            st_d  = q_entry_i.last_point ? StEmit : StIdle;
          end else if (await_q) begin
            for (int j = 0; j < NUM_JOINTS; j++) begin
              if (JntW'(j) < q_entry_i.n_joints) begin
                start_d[j] = q_entry_i.joint_pos[j];
                prev_d[j]  = q_entry_i.joint_pos[j];
              end
            end
            ptime_d = q_entry_i.time_ns;
            await_d = 1'b0;
            st_d    = q_entry_i.last_point ? StEmit : StIdle;
          end else begin
            k_d   = '0;
            sum_d = '0;
            st_d  = StSq;
          end
        end
      end
      StSq: begin
        if (k_q != '0) begin
          sum_d = sum_q + SumW'(prod_q);
        end
        if (k_q == cur_q.n_joints) begin
          rad_d  = RadW'(sum_d);
          rem_d  = '0;
          root_d = '0;
          it_d   = '0;
          st_d   = StSqrt;
        end else begin
          prod_d = SqW'(dmag) * SqW'(dmag);
          k_d    = k_q + JntW'(1);
        end
      end
      StSqrt: begin
        rad_d = {rad_q[RadW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[RootW-2:0], 1'b0};
        end
        it_d = it_q + IterW'(1);
        if (it_q == IterW'(RootW - 1)) begin
          st_d = StAcc;
        end
      end
      StAcc: begin
        acc_d = acc_sum[LenW] ? '1 : acc_sum[LenW-1:0];
        for (int j = 0; j < NUM_JOINTS; j++) begin
          if (JntW'(j) < cur_q.n_joints) begin
            prev_d[j] = cur_q.joint_pos[j];
          end
        end
        ptime_d = cur_q.time_ns;
        st_d    = cur_q.last_point ? StEmit : StIdle;
      end
      StEmit: begin
        if (out_free) begin
          rv_d   = 1'b1;
          rs_d   = err_q;
          rlen_d = err_q ? '0 : acc_q;
          rdur_d = err_q ? '0 : cur_q.time_ns[DurW-1:0];
          rtrv_d = err_q ? '0 : trav;
          for (int j = 0; j < NUM_JOINTS; j++) begin
            prev_d[j]  = '0;
            start_d[j] = '0;
          end
          ptime_d = '0;
          acc_d   = '0;
          await_d = 1'b1;
          err_d   = 1'b0;
          st_d    = StIdle;
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      for (int j = 0; j < NUM_JOINTS; j++) begin
        prev_q[j]  <= '0;
        start_q[j] <= '0;
      end
      ptime_q <= '0;
      acc_q   <= '0;
      await_q <= 1'b1;
      err_q   <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      prev_q  <= prev_d;
      start_q <= start_d;
      ptime_q <= ptime_d;
      acc_q   <= acc_d;
      await_q <= await_d;
      err_q   <= err_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    k_q    <= k_d;
    prod_q <= prod_d;
    sum_q  <= sum_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    it_q   <= it_d;
    rs_q   <= rs_d;
    rlen_q <= rlen_d;
    rdur_q <= rdur_d;
    rtrv_q <= rtrv_d;
  end

endmodule
